FILE: hdl/rcrd_pkg.sv
// Package for the channel record decoder.
// Pipeline depth, field widths, decode constants and the stage-control struct.
// Used by every module in hdl/.
package rcrd_pkg;

    // Pipeline depth: three decode stages plus the output register
    localparam int NUM_STAGES = 4;

    // Field widths
    localparam int FREQ_W   = 32;
    localparam int TONE_W   = 16;
    localparam int FLAGS_W  = 8;
    localparam int HZ_W     = 31;
    localparam int CTCSS_W  = 13;
    localparam int DCS_W    = 14;

    // Internal widths: two-digit pair, four-digit group, eight-digit sum
    localparam int PAIR_W   = 8;   // at most 165
    localparam int QUAD_W   = 15;  // at most 16665
    localparam int OCT_W    = 28;  // at most 166666665

    // Decode constants
    localparam logic [FREQ_W-1:0] FREQ_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [TONE_W-1:0] TONE_ALL_ONES = 16'hFFFF;
    localparam logic [QUAD_W-1:0] DCS_BASE      = 15'd8000;
    localparam logic [QUAD_W-1:0] DCS_INV_BASE  = 15'd12000;
    localparam logic [OCT_W-1:0]  QUAD_SCALE    = 28'd10000;

    // Flag byte bit positions
    localparam int FLAG_NO_BCL   = 0;
    localparam int FLAG_NO_SCRAM = 1;
    localparam int FLAG_NARROW   = 2;
    localparam int FLAG_HIGH_PWR = 3;
    localparam int FLAG_NO_SCAN  = 4;
    localparam int FLAG_USED_W   = 5;

    // Load enables for each pipeline stage
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctrl;

    // Two BCD digits to a binary value (digits above 9 weighted as they stand)
    function automatic logic [PAIR_W-1:0] pair_sum(input logic [3:0] hi, input logic [3:0] lo);
        pair_sum = PAIR_W'(hi) * PAIR_W'(10) + PAIR_W'(lo);
    endfunction

    // Two digit pairs to a four-digit value
    function automatic logic [QUAD_W-1:0] quad_sum(input logic [PAIR_W-1:0] hi,
                                                   input logic [PAIR_W-1:0] lo);
        quad_sum = QUAD_W'(hi) * QUAD_W'(100) + QUAD_W'(lo);
    endfunction

endpackage

FILE: hdl/radio_channel_record_decoder.sv
// Top level of the channel record decoder: pipeline control, frequency and
// tone decoders, flag pipeline and output register.
// Depends on rcrd_pkg, rcrd_pipe_ctrl, rcrd_freq_dec, rcrd_tone_dec.
//
// Usage:
//   Input channel: i_valid / o_stall with one stored channel record on the
//   i_* field ports. A record transfers on a rising edge with i_valid high
//   and o_stall low.
//   Output channel: o_valid / i_stall with the decoded fields on o_* ports.
//   A result transfers on a rising edge with o_valid high and i_stall low.
//   A record passes the three decode stages and the output register on
//   its way to o_valid. Throughput: one record per cycle while i_stall is
//   low; the four-stage pipeline holds up to four records in flight.
//   An empty channel (receive frequency zero or all ones) gives
//   o_channel_valid low and every other field zero.
//   While i_stall holds, the output register and its payload stay put; the
//   stages behind it keep filling bubbles and o_stall rises only when the
//   pipeline is full, so nothing is dropped or repeated.
//   Reset (i_rst_n low at a clock edge) empties the pipeline; o_valid is
//   low after it.
module radio_channel_record_decoder import rcrd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [FREQ_W-1:0]        i_rx_freq_bcd,
    input  logic [FREQ_W-1:0]        i_tx_freq_bcd,
    input  logic [TONE_W-1:0]        i_rx_tone_code,
    input  logic [TONE_W-1:0]        i_tx_tone_code,
    input  logic [FLAGS_W-1:0]       i_channel_flags,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_channel_valid,
    output logic [HZ_W-1:0]          o_rx_hz,
    output logic [HZ_W-1:0]          o_tx_hz,
    output logic [CTCSS_W-1:0]       o_rx_ctcss,
    output logic [CTCSS_W-1:0]       o_tx_ctcss,
    output logic signed [DCS_W-1:0]  o_rx_dcs,
    output logic signed [DCS_W-1:0]  o_tx_dcs,
    output logic                     o_low_power,
    output logic                     o_wide_band,
    output logic                     o_scan_on,
    output logic                     o_busy_lockout,
    output logic                     o_scramble_on
);

    t_pipe_ctrl              ctrl;
    logic [OCT_W-1:0]        rx_sum;
    logic [OCT_W-1:0]        tx_sum;
    logic [CTCSS_W-1:0]      rx_ctcss;
    logic [CTCSS_W-1:0]      tx_ctcss;
    logic signed [DCS_W-1:0] rx_dcs;
    logic signed [DCS_W-1:0] tx_dcs;

    // Side pipeline for the empty-channel mark and the used flag bits
    logic                   r_full  [NUM_STAGES-1];
    logic [FLAG_USED_W-1:0] r_flags [NUM_STAGES-1];

    // Output register
    logic                    r_chan_valid;
    logic [HZ_W-1:0]         r_rx_hz;
    logic [HZ_W-1:0]         r_tx_hz;
    logic [CTCSS_W-1:0]      r_rx_ctcss;
    logic [CTCSS_W-1:0]      r_tx_ctcss;
    logic signed [DCS_W-1:0] r_rx_dcs;
    logic signed [DCS_W-1:0] r_tx_dcs;
    logic [FLAG_USED_W-1:0]  r_flags_out;

    logic [OCT_W+3:0]        rx_hz_full;
    logic [OCT_W+3:0]        tx_hz_full;

    rcrd_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctrl  (ctrl)
    );

    rcrd_freq_dec u_rx_freq (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_bcd  (i_rx_freq_bcd),
        .o_sum  (rx_sum)
    );

    rcrd_freq_dec u_tx_freq (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_bcd  (i_tx_freq_bcd),
        .o_sum  (tx_sum)
    );

    rcrd_tone_dec u_rx_tone (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_code  (i_rx_tone_code),
        .o_ctcss (rx_ctcss),
        .o_dcs   (rx_dcs)
    );

    rcrd_tone_dec u_tx_tone (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_code  (i_tx_tone_code),
        .o_ctcss (tx_ctcss),
        .o_dcs   (tx_dcs)
    );

    // Empty-channel mark and flags ride along with the decode stages
    always_ff @(posedge i_clk) begin
        if (ctrl.en[0]) begin
            r_full[0]  <= (i_rx_freq_bcd != '0) && (i_rx_freq_bcd != FREQ_ALL_ONES);
            r_flags[0] <= i_channel_flags[FLAG_USED_W-1:0];
        end
        for (int k = 1; k < NUM_STAGES - 1; k++) begin
            if (ctrl.en[k]) begin
                r_full[k]  <= r_full[k-1];
                r_flags[k] <= r_flags[k-1];
            end
        end
    end

    // Times ten: shift-and-add
    assign rx_hz_full = {rx_sum, 3'b000} + {3'b000, rx_sum, 1'b0};
    assign tx_hz_full = {tx_sum, 3'b000} + {3'b000, tx_sum, 1'b0};

    // Output register, fields cleared for an empty channel
    always_ff @(posedge i_clk) begin
        if (ctrl.en[NUM_STAGES-1]) begin
            r_chan_valid <= r_full[NUM_STAGES-2];
            if (r_full[NUM_STAGES-2]) begin
                r_rx_hz     <= rx_hz_full[HZ_W-1:0];
                r_tx_hz     <= tx_hz_full[HZ_W-1:0];
                r_rx_ctcss  <= rx_ctcss;
                r_tx_ctcss  <= tx_ctcss;
                r_rx_dcs    <= rx_dcs;
                r_tx_dcs    <= tx_dcs;
                r_flags_out <= ~r_flags[NUM_STAGES-2];
            end else begin
                r_rx_hz     <= '0;
                r_tx_hz     <= '0;
                r_rx_ctcss  <= '0;
                r_tx_ctcss  <= '0;
                r_rx_dcs    <= '0;
                r_tx_dcs    <= '0;
                r_flags_out <= '0;
            end
        end
    end

    assign o_channel_valid = r_chan_valid;
    assign o_rx_hz         = r_rx_hz;
    assign o_tx_hz         = r_tx_hz;
    assign o_rx_ctcss      = r_rx_ctcss;
    assign o_tx_ctcss      = r_tx_ctcss;
    assign o_rx_dcs        = r_rx_dcs;
    assign o_tx_dcs        = r_tx_dcs;
    assign o_low_power     = r_flags_out[FLAG_HIGH_PWR];
    assign o_wide_band     = r_flags_out[FLAG_NARROW];
    assign o_scan_on       = r_flags_out[FLAG_NO_SCAN];
    assign o_busy_lockout  = r_flags_out[FLAG_NO_BCL];
    assign o_scramble_on   = r_flags_out[FLAG_NO_SCRAM];

endmodule

FILE: hdl/rcrd_pipe_ctrl.sv
// Valid bits and load enables for the decoder pipeline.
// Depends on rcrd_pkg.
module rcrd_pipe_ctrl import rcrd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output t_pipe_ctrl o_ctrl
);

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] n_v;
    logic [NUM_STAGES-1:0] ready;

    // A stage may load when it is empty or the one after it moves on
    always_comb begin
        ready[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ready[k] = !r_v[k] || ready[k+1];
        end
    end

    // Next valid bits
    always_comb begin
        n_v = r_v;
        if (ready[0]) begin
            n_v[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (ready[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ctrl.en = ready;
    assign o_stall   = !ready[0];
    assign o_valid   = r_v[NUM_STAGES-1];

endmodule

FILE: hdl/rcrd_freq_dec.sv
// Three-stage BCD frequency decoder: digit pairs, four-digit groups, full sum.
// Depends on rcrd_pkg.
module rcrd_freq_dec import rcrd_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_ctrl        i_ctrl,
    input  logic [FREQ_W-1:0] i_bcd,
    output logic [OCT_W-1:0]  o_sum
);

    logic [PAIR_W-1:0] r_pair [4];
    logic [QUAD_W-1:0] r_quad [2];
    logic [OCT_W-1:0]  r_sum;

    // Stage 1: pairs of digits, most significant pair first
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            for (int p = 0; p < 4; p++) begin
                r_pair[p] <= pair_sum(i_bcd[FREQ_W-1-8*p -: 4], i_bcd[FREQ_W-5-8*p -: 4]);
            end
        end
    end

    // Stage 2: four-digit groups
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[1]) begin
            r_quad[0] <= quad_sum(r_pair[0], r_pair[1]);
            r_quad[1] <= quad_sum(r_pair[2], r_pair[3]);
        end
    end

    // Stage 3: eight-digit sum
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[2]) begin
            r_sum <= OCT_W'(r_quad[0]) * QUAD_SCALE + OCT_W'(r_quad[1]);
        end
    end

    assign o_sum = r_sum;

endmodule

FILE: hdl/rcrd_tone_dec.sv
// Three-stage squelch code decoder: digit pairs, index, CTCSS/DCS split.
// Depends on rcrd_pkg.
module rcrd_tone_dec import rcrd_pkg::*; (
    input  logic                     i_clk,
    input  t_pipe_ctrl               i_ctrl,
    input  logic [TONE_W-1:0]        i_code,
    output logic [CTCSS_W-1:0]       o_ctcss,
    output logic signed [DCS_W-1:0]  o_dcs
);

    logic [PAIR_W-1:0]       r_hi;
    logic [PAIR_W-1:0]       r_lo;
    logic                    r_none1;
    logic [QUAD_W-1:0]       r_idx;
    logic                    r_none2;
    logic [CTCSS_W-1:0]      r_ctcss;
    logic signed [DCS_W-1:0] r_dcs;

    logic [CTCSS_W-1:0]      n_ctcss;
    logic signed [DCS_W-1:0] n_dcs;
    logic [QUAD_W-1:0]       dcs_norm;
    logic [QUAD_W-1:0]       dcs_inv;

    // Stage 1: digit pairs and the no-squelch codes
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r_hi    <= pair_sum(i_code[15:12], i_code[11:8]);
            r_lo    <= pair_sum(i_code[7:4], i_code[3:0]);
            r_none1 <= (i_code == '0) || (i_code == TONE_ALL_ONES);
        end
    end

    // Stage 2: tone index
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[1]) begin
            r_idx   <= quad_sum(r_hi, r_lo);
            r_none2 <= r_none1;
        end
    end

    // Stage 3: range split into CTCSS, normal DCS or inverted DCS
    assign dcs_norm = r_idx - DCS_BASE;
    assign dcs_inv  = DCS_INV_BASE - r_idx;

    always_comb begin
        n_ctcss = '0;
        n_dcs   = '0;
        if (!r_none2) begin
            if (r_idx < DCS_BASE) begin
                n_ctcss = r_idx[CTCSS_W-1:0];
            end else if (r_idx < DCS_INV_BASE) begin
                n_dcs = signed'(dcs_norm[DCS_W-1:0]);
            end else begin
                n_dcs = signed'(dcs_inv[DCS_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[2]) begin
            r_ctcss <= n_ctcss;
            r_dcs   <= n_dcs;
        end
    end

    assign o_ctcss = r_ctcss;
    assign o_dcs   = r_dcs;

endmodule
